// File: hdl/vmef_pkg.sv
// shared types, constants and command/status structs of the motor energy fuse
package vmef_pkg;

    localparam int LOAD_W  = 20;
    localparam int K_W     = 14;
    localparam int TIME_W  = 32;
    localparam int DUTY_W  = 16;
    localparam int OMS_W   = 13;
    localparam int ODUTY_W = 10;
    localparam int CD_W    = 12;
    localparam int PCT_W   = 7;
    localparam int PROD_W  = 64;
    localparam int Q_W     = 34;
    localparam int REM_W   = 30;
    localparam int QUOT_W  = 20;
    localparam int NUM_W   = 50;

    localparam logic [LOAD_W-1:0] LOAD_MAX  = 20'd786432;
    localparam logic [LOAD_W-1:0] LOAD_SOFT = 20'd262144;
    localparam logic [LOAD_W-1:0] LOAD_MID  = 20'd393216;
    localparam logic [LOAD_W-1:0] LOAD_HARD = 20'd524288;

    localparam logic [K_W-1:0]    WINDOW_MS    = 14'd10000;
    localparam logic [TIME_W-1:0] COOLDOWN_MS  = 32'd3000;
    localparam logic [DUTY_W-1:0] DUTY_FULL    = 16'd1023;
    localparam logic [DUTY_W-1:0] DUTY_CAP_MID = 16'd800;
    localparam logic [DUTY_W-1:0] DUTY_CAP_HI  = 16'd600;
    localparam logic [TIME_W-1:0] SOFT_MAX_MS  = 32'd800;
    localparam logic [TIME_W-1:0] MAX_MS       = 32'd5000;

    // floor(x / 10000) = ((x >> 4) * DECAY_RCP) >> 39 for x < 2^33
    localparam logic [29:0] DECAY_RCP = 30'd879609303;
    localparam int          DECAY_SH  = 39;

    // floor(y / 25) = (y * FLOOR_RCP) >> 20 for y < 2^15
    localparam logic [15:0] FLOOR_RCP = 16'd41944;
    localparam int          FLOOR_SH  = 20;

    localparam logic [REM_W-1:0] ENERGY_DIV = 30'd1046529000;
    localparam logic [Q_W-1:0]   ENERGY_SAT = 34'd12558348000;

    // ((q >> 2) * ENERGY_RCP) >> 43 is floor(q * 2^16 / ENERGY_DIV) or one below it
    localparam logic [31:0] ENERGY_RCP = 32'd2203324522;
    localparam int          ENERGY_SH  = 43;

    localparam logic [PCT_W-1:0]   PCT_MAX       = 7'd100;
    localparam logic [PCT_W-1:0]   MIN_PCT_RESET = 7'd50;
    localparam logic [ODUTY_W-1:0] FLOOR_RESET   = 10'd511;

    localparam logic [1:0] REQ_CHECK  = 2'd0;
    localparam logic [1:0] REQ_RECORD = 2'd1;
    localparam logic [1:0] SIDE_LEFT  = 2'd0;
    localparam logic [1:0] SIDE_RIGHT = 2'd1;

    typedef enum logic [2:0] {
        MUL_LEFT_K,
        MUL_RIGHT_K,
        MUL_RECIP,
        MUL_DUTY_SQ,
        MUL_ENERGY
    } t_mul_sel;

    typedef struct packed {
        logic     capture;
        logic     prep;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     sub_left;
        logic     sub_right;
        logic     check;
        logic     div_start;
        logic     add_energy;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic do_decay;
        logic is_check;
        logic is_record;
        logic div_done;
    } t_status;

endpackage

// File: hdl/vmef_energy_div.sv
// reciprocal divider for the record energy, quotient estimate and one correction step
module vmef_energy_div
    import vmef_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [Q_W-1:0]    i_num,
    output logic              o_done,
    output logic [QUOT_W-1:0] o_quot
);

    logic [Q_W-1:0]    r_num;
    logic [PROD_W-1:0] r_mul;
    logic [QUOT_W-1:0] r_qa;
    logic [NUM_W-1:0]  r_back;
    logic [QUOT_W-1:0] r_quot;
    logic              r_mul_vld;
    logic              r_back_vld;
    logic              r_done;
    logic [QUOT_W-1:0] n_qa;
    logic [NUM_W-1:0]  n_rem;

    assign n_qa  = r_mul[ENERGY_SH +: QUOT_W];
    assign n_rem = {r_num, 16'd0} - r_back;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_vld  <= 1'b0;
            r_back_vld <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_mul_vld  <= i_start;
            r_back_vld <= r_mul_vld;
            r_done     <= r_back_vld;
        end
    end

    // numerator is i_num << 16, estimate may be one low
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_mul <= 64'(i_num[Q_W-1:2]) * 64'(ENERGY_RCP);
        end
        if (r_mul_vld) begin
            r_qa   <= n_qa;
            r_back <= NUM_W'(n_qa) * NUM_W'(ENERGY_DIV);
        end
        if (r_back_vld) begin
            r_quot <= (n_rem >= NUM_W'(ENERGY_DIV)) ? r_qa + 1'b1 : r_qa;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// File: hdl/vmef_datapath.sv
// datapath: item registers, motor loads, shared multiplier, check logic, result register
module vmef_datapath
    import vmef_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  logic               i_cfg_we,
    input  logic [PCT_W-1:0]   i_cfg_pct,
    output logic [PCT_W-1:0]   o_min_pct,
    input  logic [1:0]         i_req_type,
    input  logic [1:0]         i_side,
    input  logic [TIME_W-1:0]  i_now_ms,
    input  logic [TIME_W-1:0]  i_req_ms,
    input  logic [DUTY_W-1:0]  i_req_duty,
    output logic               o_granted,
    output logic [OMS_W-1:0]   o_out_ms,
    output logic [ODUTY_W-1:0] o_out_duty,
    output logic [LOAD_W-1:0]  o_load_left,
    output logic [LOAD_W-1:0]  o_load_right,
    output logic [CD_W-1:0]    o_cooldown_left
);

    logic [1:0]         r_type;
    logic [1:0]         r_side;
    logic [TIME_W-1:0]  r_now;
    logic [TIME_W-1:0]  r_ms;
    logic [DUTY_W-1:0]  r_duty;
    logic [K_W-1:0]     r_k;
    logic [TIME_W-1:0]  r_last;
    logic [LOAD_W-1:0]  r_left;
    logic [LOAD_W-1:0]  r_right;
    logic [TIME_W-1:0]  r_cend;
    logic [PROD_W-1:0]  r_prod;
    logic               r_granted;
    logic [OMS_W-1:0]   r_gms;
    logic [ODUTY_W-1:0] r_gduty;
    logic [PCT_W-1:0]   r_min_pct;
    logic [ODUTY_W-1:0] r_floor_duty;
    logic               r_o_granted;
    logic [OMS_W-1:0]   r_o_ms;
    logic [ODUTY_W-1:0] r_o_duty;
    logic [LOAD_W-1:0]  r_o_left;
    logic [LOAD_W-1:0]  r_o_right;
    logic [CD_W-1:0]    r_o_cd;

    logic [TIME_W-1:0]  n_dt;
    logic [K_W-1:0]     n_k;
    logic [31:0]        n_mul_a;
    logic [31:0]        n_mul_b;
    logic [PCT_W-1:0]   n_pct;
    logic [16:0]        n_pct_x;
    logic [30:0]        n_floor_p;
    logic [LOAD_W-1:0]  n_ref;
    logic               n_soft;
    logic [DUTY_W-1:0]  n_cap;
    logic [DUTY_W-1:0]  n_duty_a;
    logic [DUTY_W-1:0]  n_duty_b;
    logic [DUTY_W-1:0]  n_duty_c;
    logic [TIME_W-1:0]  n_ms_a;
    logic [TIME_W-1:0]  n_ms_b;
    logic [LOAD_W-1:0]  n_energy;
    logic [LOAD_W:0]    n_sum_l;
    logic [LOAD_W:0]    n_sum_r;
    logic [TIME_W-1:0]  n_cd_full;
    logic [CD_W-1:0]    n_cd;
    logic               n_div_done;
    logic [QUOT_W-1:0]  n_quot;

    // decay window
    assign n_dt = r_now - r_last;
    assign n_k  = (n_dt > TIME_W'(WINDOW_MS)) ? WINDOW_MS : n_dt[K_W-1:0];

    // config: duty floor = min_pct * 1023 / 100
    assign n_pct     = (i_cfg_pct > PCT_MAX) ? PCT_MAX : i_cfg_pct;
    assign n_pct_x   = ({n_pct, 10'd0}) - 17'(n_pct);
    assign n_floor_p = 31'(n_pct_x[16:2]) * 31'(FLOOR_RCP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_pct    <= MIN_PCT_RESET;
            r_floor_duty <= FLOOR_RESET;
        end else if (i_cfg_we) begin
            r_min_pct    <= n_pct;
            r_floor_duty <= n_floor_p[FLOOR_SH +: ODUTY_W];
        end
    end

    assign o_min_pct = r_min_pct;

    // shared multiplier operands
    always_comb begin
        n_mul_a = '0;
        n_mul_b = '0;
        case (i_cmd.mul_sel)
            MUL_LEFT_K: begin
                n_mul_a = 32'(r_left);
                n_mul_b = 32'(r_k);
            end
            MUL_RIGHT_K: begin
                n_mul_a = 32'(r_right);
                n_mul_b = 32'(r_k);
            end
            MUL_RECIP: begin
                n_mul_a = 32'(r_prod[32:4]);
                n_mul_b = 32'(DECAY_RCP);
            end
            MUL_DUTY_SQ: begin
                n_mul_a = 32'(r_duty);
                n_mul_b = 32'(r_duty);
            end
            MUL_ENERGY: begin
                n_mul_a = r_prod[31:0];
                n_mul_b = r_ms;
            end
            default: begin
                n_mul_a = '0;
                n_mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_type <= i_req_type;
            r_side <= i_side;
            r_now  <= i_now_ms;
            r_ms   <= i_req_ms;
            r_duty <= i_req_duty;
        end
        if (i_cmd.prep) begin
            r_k <= n_k;
        end
        if (i_cmd.mul_en) begin
            r_prod <= 64'(n_mul_a) * 64'(n_mul_b);
        end
    end

    // check path
    always_comb begin
        if (r_side == SIDE_LEFT) begin
            n_ref = r_left;
        end else if (r_side == SIDE_RIGHT) begin
            n_ref = r_right;
        end else begin
            n_ref = (r_left > r_right) ? r_left : r_right;
        end
        n_soft   = (n_ref >= LOAD_SOFT);
        n_cap    = (n_ref < LOAD_MID) ? DUTY_CAP_MID : DUTY_CAP_HI;
        n_duty_a = (n_soft && (r_duty > n_cap)) ? n_cap : r_duty;
        n_duty_b = (n_duty_a < DUTY_W'(r_floor_duty)) ? DUTY_W'(r_floor_duty) : n_duty_a;
        n_duty_c = (n_duty_b > DUTY_FULL) ? DUTY_FULL : n_duty_b;
        n_ms_a   = (n_soft && (r_ms > SOFT_MAX_MS)) ? SOFT_MAX_MS : r_ms;
        n_ms_b   = (n_ms_a > MAX_MS) ? MAX_MS : n_ms_a;
    end

    // record path
    vmef_energy_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_prod[Q_W-1:0]),
        .o_done  (n_div_done),
        .o_quot  (n_quot)
    );

    assign n_energy = (r_prod >= PROD_W'(ENERGY_SAT)) ? LOAD_MAX : n_quot;
    assign n_sum_l  = {1'b0, r_left} + {1'b0, n_energy};
    assign n_sum_r  = {1'b0, r_right} + {1'b0, n_energy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last  <= '0;
            r_left  <= '0;
            r_right <= '0;
            r_cend  <= '0;
        end else begin
            if (i_cmd.prep) begin
                r_last <= r_now;
            end
            if (i_cmd.sub_left) begin
                r_left <= r_left - r_prod[DECAY_SH +: LOAD_W];
            end
            if (i_cmd.sub_right) begin
                r_right <= r_right - r_prod[DECAY_SH +: LOAD_W];
            end
            if (i_cmd.check && (r_now >= r_cend) && (n_ref >= LOAD_HARD)) begin
                r_cend <= r_now + COOLDOWN_MS;
            end
            if (i_cmd.add_energy) begin
                if (r_side != SIDE_RIGHT) begin
                    r_left <= (n_sum_l > {1'b0, LOAD_MAX}) ? LOAD_MAX : n_sum_l[LOAD_W-1:0];
                end
                if (r_side != SIDE_LEFT) begin
                    r_right <= (n_sum_r > {1'b0, LOAD_MAX}) ? LOAD_MAX : n_sum_r[LOAD_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_granted <= 1'b0;
            r_gms     <= '0;
            r_gduty   <= '0;
        end else if (i_cmd.check && (r_now >= r_cend) && (n_ref < LOAD_HARD)) begin
            r_granted <= 1'b1;
            r_gms     <= n_ms_b[OMS_W-1:0];
            r_gduty   <= n_duty_c[ODUTY_W-1:0];
        end
    end

    // remaining cooldown
    assign n_cd_full = r_cend - r_now;
    always_comb begin
        if (r_now < r_cend) begin
            n_cd = (n_cd_full > COOLDOWN_MS) ? CD_W'(COOLDOWN_MS) : n_cd_full[CD_W-1:0];
        end else begin
            n_cd = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_granted <= r_granted;
            r_o_ms      <= r_gms;
            r_o_duty    <= r_gduty;
            r_o_left    <= r_left;
            r_o_right   <= r_right;
            r_o_cd      <= n_cd;
        end
    end

    assign o_status.do_decay  = (r_last != '0) && (n_dt != '0);
    assign o_status.is_check  = (r_type == REQ_CHECK);
    assign o_status.is_record = (r_type == REQ_RECORD);
    assign o_status.div_done  = n_div_done;

    assign o_granted       = r_o_granted;
    assign o_out_ms        = r_o_ms;
    assign o_out_duty      = r_o_duty;
    assign o_load_left     = r_o_left;
    assign o_load_right    = r_o_right;
    assign o_cooldown_left = r_o_cd;

endmodule

// File: hdl/vmef_ctrl.sv
// controller: sequences decay, check and record steps, owns both handshakes
module vmef_ctrl
    import vmef_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [14:0] {
        S_IDLE      = 15'b000000000000001,
        S_PREP      = 15'b000000000000010,
        S_DL_MUL    = 15'b000000000000100,
        S_DL_DIV    = 15'b000000000001000,
        S_DL_SUB    = 15'b000000000010000,
        S_DR_MUL    = 15'b000000000100000,
        S_DR_DIV    = 15'b000000001000000,
        S_DR_SUB    = 15'b000000010000000,
        S_OP        = 15'b000000100000000,
        S_E_SQ      = 15'b000001000000000,
        S_E_MUL     = 15'b000010000000000,
        S_E_START   = 15'b000100000000000,
        S_E_WAIT    = 15'b001000000000000,
        S_E_ADD     = 15'b010000000000000,
        S_OUT       = 15'b100000000000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_free;

    assign n_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.mul_sel = MUL_LEFT_K;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state = i_status.do_decay ? S_DL_MUL : S_OP;
            end
            S_DL_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_LEFT_K;
                n_state = S_DL_DIV;
            end
            S_DL_DIV: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_RECIP;
                n_state = S_DL_SUB;
            end
            S_DL_SUB: begin
                o_cmd.sub_left = 1'b1;
                n_state = S_DR_MUL;
            end
            S_DR_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_RIGHT_K;
                n_state = S_DR_DIV;
            end
            S_DR_DIV: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_RECIP;
                n_state = S_DR_SUB;
            end
            S_DR_SUB: begin
                o_cmd.sub_right = 1'b1;
                n_state = S_OP;
            end
            S_OP: begin
                if (i_status.is_check) begin
                    o_cmd.check = 1'b1;
                    n_state = S_OUT;
                end else if (i_status.is_record) begin
                    n_state = S_E_SQ;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_E_SQ: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_DUTY_SQ;
                n_state = S_E_MUL;
            end
            S_E_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_ENERGY;
                n_state = S_E_START;
            end
            S_E_START: begin
                o_cmd.div_start = 1'b1;
                n_state = S_E_WAIT;
            end
            S_E_WAIT: begin
                if (i_status.div_done) begin
                    n_state = S_E_ADD;
                end
            end
            S_E_ADD: begin
                o_cmd.add_energy = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (n_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: hdl/vibration_motor_energy_fuse.sv
// sequence: capture, prep, decay when due, then per type: check items run the check step,
// record items a duty square, energy multiply and the two-multiply reciprocal energy divide
// with one correction step; decay uses two multiplies per motor on the one shared multiplier
// throughput: one transaction in flight, the next is accepted the cycle after its result loads
// reset: synchronous active low, clears loads, last time, cooldown end, min_pct to 50
// and the result register valid; no clearing pass
module vibration_motor_energy_fuse
    import vmef_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_req_type,
    input  logic [1:0]         i_side,
    input  logic [TIME_W-1:0]  i_now_ms,
    input  logic [TIME_W-1:0]  i_req_ms,
    input  logic [DUTY_W-1:0]  i_req_duty,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_granted,
    output logic [OMS_W-1:0]   o_out_ms,
    output logic [ODUTY_W-1:0] o_out_duty,
    output logic [LOAD_W-1:0]  o_load_left,
    output logic [LOAD_W-1:0]  o_load_right,
    output logic [CD_W-1:0]    o_cooldown_left
);

    t_cmd             w_cmd;
    t_status          w_status;
    logic             w_cfg_we;
    logic [PCT_W-1:0] w_min_pct;

    // register decode
    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata   = (paddr[2] == 1'b0) ? 32'(w_min_pct) : 32'd0;

    vmef_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    vmef_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_cfg_we        (w_cfg_we),
        .i_cfg_pct       (pwdata[PCT_W-1:0]),
        .o_min_pct       (w_min_pct),
        .i_req_type      (i_req_type),
        .i_side          (i_side),
        .i_now_ms        (i_now_ms),
        .i_req_ms        (i_req_ms),
        .i_req_duty      (i_req_duty),
        .o_granted       (o_granted),
        .o_out_ms        (o_out_ms),
        .o_out_duty      (o_out_duty),
        .o_load_left     (o_load_left),
        .o_load_right    (o_load_right),
        .o_cooldown_left (o_cooldown_left)
    );

endmodule

// File: hdl/vmef_checker.sv
// port-level checker for the motor energy fuse and its bind
module vmef_checker
    import vmef_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic               o_granted,
    input logic [OMS_W-1:0]   o_out_ms,
    input logic [ODUTY_W-1:0] o_out_duty,
    input logic [LOAD_W-1:0]  o_load_left,
    input logic [LOAD_W-1:0]  o_load_right,
    input logic [CD_W-1:0]    o_cooldown_left
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_granted)
            && $stable(o_out_ms) && $stable(o_out_duty) && $stable(o_load_left)
            && $stable(o_load_right) && $stable(o_cooldown_left))
        else $error("result changed while stalled");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_granted |-> (o_out_ms == '0) && (o_out_duty == '0))
        else $error("refused transaction carries duty or time");

    a_grant_no_cooldown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_granted |-> (o_cooldown_left == '0) && (o_out_ms <= 13'd5000))
        else $error("grant during cooldown or time above limit");

    a_load_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_load_left <= LOAD_MAX) && (o_load_right <= LOAD_MAX)
            && (o_cooldown_left <= 12'd3000))
        else $error("load or cooldown out of range");

endmodule

bind vibration_motor_energy_fuse vmef_checker u_vmef_checker (.*);
